>>> rtl/swsl_pkg.sv
// Package for the page stack with sorted listing.
// Holds default sizes, request and status codes, and the controller/datapath bundles.
// No dependencies.
package swsl_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int PAGE_BITS_DEF = 10;
  localparam int CFG_BITS      = 10;
  localparam logic [CFG_BITS-1:0] MAX_PAGE_RST = 10'd1000;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_LIST = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;     // latch the accepted item
    logic push_out;    // check, store and answer a push
    logic pop_rd;      // read top entry, drop count
    logic pop_out;     // answer a pop with the read data
    logic empty_out;   // answer with the empty status
    logic list_start;  // clear the emitted count
    logic scan_start;  // restart a minimum search pass
    logic scan_step;   // read next entry of the pass
    logic list_emit;   // emit the minimum found
  } swsl_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic cnt_zero;
    logic out_free;
    logic scan_end;
    logic emit_end;
  } swsl_sts_t;

endpackage

>>> rtl/swsl_ifs.sv
// Valid/ready channel interfaces for requests and results.
// Depends on swsl_pkg.
interface swsl_req_if #(
  parameter int PAGE_BITS = swsl_pkg::PAGE_BITS_DEF
);
  import swsl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [PAGE_BITS-1:0] page_in;

  modport source (output valid, req_type, page_in, input ready);
  modport sink   (input valid, req_type, page_in, output ready);
endinterface

interface swsl_rsp_if #(
  parameter int PAGE_BITS = swsl_pkg::PAGE_BITS_DEF
);
  import swsl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_out;
  logic [1:0]           status;
  logic                 last;

  modport source (output valid, page_out, status, last, input ready);
  modport sink   (input valid, page_out, status, last, output ready);
endinterface

>>> rtl/swsl_ctrl.sv
// Controller state machine of the page stack.
// Depends on swsl_pkg; drives swsl_dp through swsl_cmd_t.
module swsl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic [1:0]         req_type,
  output logic               req_ready,
  input  swsl_pkg::swsl_sts_t sts,
  output swsl_pkg::swsl_cmd_t cmd
);
  import swsl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PUSH, S_POP_RD, S_POP_OUT, S_EMPTY, S_SCAN, S_CMP, S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          case (req_t'(req_type))
            REQ_PUSH: state_next = S_PUSH;
            REQ_POP:  state_next = sts.cnt_zero ? S_EMPTY : S_POP_RD;
            REQ_LIST: begin
              if (sts.cnt_zero) begin
                state_next = S_EMPTY;
              end else begin
                cmd.list_start = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_next = S_POP_OUT;
      end
      S_POP_OUT: begin
        if (sts.out_free) begin
          cmd.pop_out = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.empty_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_end) begin
          state_next = S_CMP;
        end
      end
      S_CMP: state_next = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.list_emit = 1'b1;
          if (sts.emit_end) begin
            state_next = S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && (req_t'(req_type) != REQ_NONE)) |=> (state != S_IDLE))
    else $error("accepted request did not start work");

  a_one_result_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push_out, cmd.pop_out, cmd.empty_out, cmd.list_emit}))
    else $error("two result loads in one cycle");

  a_pop_read_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_rd |=> (state == S_POP_OUT))
    else $error("pop read not followed by pop answer");

endmodule

>>> rtl/swsl_dp.sv
// Datapath of the page stack: stack memory, entry count, minimum search, result register.
// Depends on swsl_pkg; commanded by swsl_ctrl.
module swsl_dp #(
  parameter int DEPTH     = swsl_pkg::DEPTH_DEF,
  parameter int PAGE_BITS = swsl_pkg::PAGE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [PAGE_BITS-1:0]         page_in,
  input  logic                         cfg_we,
  input  logic [swsl_pkg::CFG_BITS-1:0] cfg_wdata,
  input  swsl_pkg::swsl_cmd_t          cmd,
  output swsl_pkg::swsl_sts_t          sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [PAGE_BITS-1:0]         out_page,
  output logic [1:0]                   out_status,
  output logic                         out_last
);
  import swsl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (PAGE_BITS > CFG_BITS) ? PAGE_BITS : CFG_BITS;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [PAGE_BITS-1:0] mem [DEPTH];
  logic [PAGE_BITS-1:0] rd_data;
  logic [AW-1:0]        rd_addr;
  logic                 rd_en;

  logic [CFG_BITS-1:0]  max_page;
  logic [PAGE_BITS-1:0] page_hold;
  logic [CW-1:0]        count;
  logic [CW-1:0]        last_idx;
  logic [AW-1:0]        top_addr;

  logic [AW-1:0]        scan_idx;
  logic                 cmp_valid;
  logic [AW-1:0]        cmp_idx;
  logic [PAGE_BITS-1:0] best_v;
  logic [AW-1:0]        best_i;
  logic                 best_valid;
  logic [PAGE_BITS-1:0] prev_v;
  logic [AW-1:0]        prev_i;
  logic [CW-1:0]        emit_cnt;

  logic [WW-1:0]        page_w;
  logic [WW-1:0]        max_w;
  logic                 bad_range;
  logic                 is_full;
  logic                 cand;
  logic                 take_best;

  assign last_idx = count - 1'b1;
  assign top_addr = last_idx[AW-1:0];
  assign page_w   = WW'(page_hold);
  assign max_w    = WW'(max_page);
  assign bad_range = (page_w == '0) || (page_w > max_w);
  assign is_full  = (count == FULL_CNT);

  assign rd_en   = cmd.pop_rd || cmd.scan_step;
  assign rd_addr = cmd.pop_rd ? top_addr : scan_idx;

  // Order on (value, index): strictly after the last emitted key.
  assign cand = (emit_cnt == '0) || (rd_data > prev_v) ||
                ((rd_data == prev_v) && (cmp_idx > prev_i));
  assign take_best = cmp_valid && cand && (!best_valid || (rd_data < best_v));

  assign sts.cnt_zero = (count == '0);
  assign sts.out_free = !out_valid || out_ready;
  assign sts.scan_end = (scan_idx == top_addr);
  assign sts.emit_end = (emit_cnt == last_idx);

  always_ff @(posedge clk) begin
    if (cmd.push_out && !bad_range && !is_full) begin
      mem[count[AW-1:0]] <= page_hold;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_page   <= MAX_PAGE_RST;
      count      <= '0;
      out_valid  <= 1'b0;
      cmp_valid  <= 1'b0;
      best_valid <= 1'b0;
      emit_cnt   <= '0;
    end else begin
      if (cfg_we) begin
        max_page <= cfg_wdata;
      end
      if (cmd.push_out && !bad_range && !is_full) begin
        count <= count + 1'b1;
      end else if (cmd.pop_rd) begin
        count <= last_idx;
      end

      cmp_valid <= cmd.scan_step;
      if (cmd.scan_start) begin
        best_valid <= 1'b0;
      end else if (take_best) begin
        best_valid <= 1'b1;
      end

      if (cmd.list_start) begin
        emit_cnt <= '0;
      end else if (cmd.list_emit) begin
        emit_cnt <= emit_cnt + 1'b1;
      end

      if (cmd.push_out || cmd.pop_out || cmd.empty_out || cmd.list_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_hold <= page_in;
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
    end
    cmp_idx <= scan_idx;
    if (take_best) begin
      best_v <= rd_data;
      best_i <= cmp_idx;
    end
    // Remember the full key of the emitted entry for the next pass.
    if (cmd.list_emit) begin
      prev_v <= best_v;
      prev_i <= best_i;
    end

    if (cmd.push_out) begin
      out_page   <= '0;
      out_last   <= 1'b1;
      out_status <= bad_range ? ST_RANGE : (is_full ? ST_FULL : ST_OK);
    end else if (cmd.pop_out) begin
      out_page   <= rd_data;
      out_last   <= 1'b1;
      out_status <= ST_OK;
    end else if (cmd.empty_out) begin
      out_page   <= '0;
      out_last   <= 1'b1;
      out_status <= ST_EMPTY;
    end else if (cmd.list_emit) begin
      out_page   <= best_v;
      out_last   <= (emit_cnt == last_idx);
      out_status <= ST_OK;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_rd |-> (count != '0))
    else $error("pop read on empty stack");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_out || cmd.pop_out || cmd.empty_out || cmd.list_emit) |-> sts.out_free)
    else $error("result register overwritten while held");

  a_emit_has_best: assert property (@(posedge clk) disable iff (rst)
    cmd.list_emit |-> best_valid)
    else $error("listing emitted without a minimum");

endmodule

>>> rtl/stack_with_sorted_listing.sv
// Page stack with push, pop and sorted listing; top level.
// Push answers from S_PUSH, pop from S_POP_RD then S_POP_OUT; a list of n entries runs n passes.
// The controller takes one request at a time; a list is paced by the single memory read port.
// Reset (synchronous rst): empty stack, max_page 1000, no result pending; memory not cleared.
// Depends on swsl_pkg, swsl_ifs, swsl_ctrl, swsl_dp.
module stack_with_sorted_listing #(
  parameter int DEPTH     = swsl_pkg::DEPTH_DEF,
  parameter int PAGE_BITS = swsl_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  swsl_req_if.sink                      req_ch,
  swsl_rsp_if.source                    rsp_ch,
  input  logic                          cfg_we,
  input  logic [swsl_pkg::CFG_BITS-1:0] cfg_wdata
);
  import swsl_pkg::*;

  // Controller and datapath talk only through these two bundles.
  swsl_cmd_t cmd;
  swsl_sts_t sts;

  // The controller takes one item at a time; ready is high only while idle.
  // A pop reads the top entry first, then answers from the registered read data.
  // A list finds the entries in ascending (value, index) order: each pass
  // sweeps the stack once through the single read port and keeps the
  // smallest key above the one emitted last, so duplicates come out once each
  // and the stack itself is never touched.
  swsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_ch.valid),
    .req_type  (req_ch.req_type),
    .req_ready (req_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The result register sits in the datapath; a result waiting there does
  // not block the next request from being accepted.
  swsl_dp #(
    .DEPTH     (DEPTH),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .page_in    (req_ch.page_in),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (rsp_ch.valid),
    .out_ready  (rsp_ch.ready),
    .out_page   (rsp_ch.page_out),
    .out_status (rsp_ch.status),
    .out_last   (rsp_ch.last)
  );

endmodule
